// ===== design/ebh_pkg.sv =====
// Shared types, constants and the fraction table generator of the exponential-bin histogram.
package ebh_pkg;

  localparam int SampleW = 16;
  localparam int BinNumW = 5;
  localparam int OutCntW = 13;
  localparam int MaxOut  = 32;
  localparam int FracW   = 17;

  localparam logic [63:0] OneQ30 = 64'd1073741824;
  localparam logic [63:0] TwoQ30 = 64'd2147483648;

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_EDGE  = 5'b00010,
    ST_BIN   = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_CLEAR = 5'b10000
  } state_e;

  // Control shared by every cell of the chain
  typedef struct packed {
    logic clear;
    logic edge_shift;
    logic cnt_shift;
  } cell_ctrl_t;

  // f[idx] = 2^(idx/nb) - 1 in Q0.16, from truncated Q2.30 powers
  function automatic logic [FracW-1:0] frac_q16(int nb, int idx);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] acc;
    logic        ok;
    lo = OneQ30;
    hi = TwoQ30;
    while (hi - lo > 64'd1) begin
      mid = lo + ((hi - lo) >> 1);
      acc = OneQ30;
      ok  = 1'b1;
      for (int k = 0; k < nb; k++) begin
        if (ok) begin
          acc = (acc * mid) >> 30;
          if (acc > TwoQ30) ok = 1'b0;
        end
      end
      if (ok) lo = mid;
      else hi = mid;
    end
    if (idx >= nb) return FracW'(65536);
    acc = OneQ30;
    for (int k = 0; k < idx; k++) acc = (acc * lo) >> 30;
    if (acc >= TwoQ30) return FracW'(65536);
    return FracW'((acc - OneQ30) >> 14);
  endfunction

endpackage

// ===== design/ebh_cell.sv =====
// One histogram cell: holds a bin edge and count, passes samples up the chain.
module ebh_cell
  import ebh_pkg::*;
#(
  parameter int CntW = 13,
  parameter bit IsTop = 1'b0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cell_ctrl_t                ctrl_i,
  input  logic signed [SampleW-1:0] edge_next_i,
  input  logic [CntW-1:0]           cnt_next_i,
  input  logic signed [SampleW-1:0] smp_i,
  input  logic                      smp_vld_i,
  output logic signed [SampleW-1:0] edge_o,
  output logic [CntW-1:0]           cnt_o,
  output logic signed [SampleW-1:0] smp_o,
  output logic                      smp_vld_o
);

  logic signed [SampleW-1:0] edge_q;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic signed [SampleW-1:0] smp_q;
  logic                      smp_vld_q;
  logic                      hit;

  // the top cell also takes everything at or above its edge
  assign hit = smp_vld_i && (edge_q <= smp_i) && (IsTop || (smp_i < edge_next_i));

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.clear) cnt_d = '0;
    else if (ctrl_i.cnt_shift) cnt_d = cnt_next_i;
    else if (hit) cnt_d = cnt_q + CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      smp_vld_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      smp_vld_q <= smp_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q <= smp_i;
    if (ctrl_i.edge_shift) edge_q <= edge_next_i;
  end

  assign edge_o    = edge_q;
  assign cnt_o     = cnt_q;
  assign smp_o     = smp_q;
  assign smp_vld_o = smp_vld_q;

endmodule

// ===== design/exponential_bin_histogram.sv =====
// Top level of the exponential-bin amplitude histogram.
//
// Input channel (valid_i/in_ready_o) carries sample_i and end_of_set_i. While
// loading, one request is taken per cycle and written to the sample store;
// min and max follow the stored samples. Samples past STORE_DEPTH are dropped
// and flag the run. The request with end_of_set_i closes the run:
//   edge build  : one shared 17x17 multiplier
//   binning     : one store read per cycle, streamed through a chain of
//                 BIN_COUNT cells
//   emit        : min(BIN_COUNT,32) results, one per cycle unless stalled,
//                 smoothed on the fly as counts shift out of the bottom cell
//   clear       : counts and run state cleared, then loading resumes
// in_ready_o is low from the closing request until the clear is done.
// The output channel (out_valid_o/out_ready_i) has one result register; a
// stalled receiver holds the emit sequence, nothing is lost.
// Reset empties the run: no samples, extremes at their limits, counts zero.
module exponential_bin_histogram
  import ebh_pkg::*;
#(
  parameter int BIN_COUNT   = 32,
  parameter int STORE_DEPTH = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      in_ready_o,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      end_of_set_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [BinNumW-1:0]        bin_number_o,
  output logic [OutCntW-1:0]        smoothed_count_o,
  output logic signed [SampleW-1:0] lower_edge_o,
  output logic                      dropped_o,
  output logic                      final_bin_o
);

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int CW    = $clog2(STORE_DEPTH + 1);
  localparam int BW    = $clog2(STORE_DEPTH + BIN_COUNT + 2);
  localparam int JW    = $clog2(BIN_COUNT + 2);
  localparam int FW    = $clog2(BIN_COUNT + 1);
  localparam int NOut  = (BIN_COUNT < MaxOut) ? BIN_COUNT : MaxOut;
  localparam int SumW  = CW + 2;
  localparam int DivSh = SumW + 1;
  localparam int DivM  = (2 ** DivSh) / 3 + 1;
  localparam int DivMW = DivSh;
  localparam int ProdW = 2 * FracW;

  state_e state_q, state_d;

  logic signed [SampleW-1:0] store_mem [STORE_DEPTH];
  logic signed [SampleW-1:0] rdata_q;
  logic                      rvld_q;

  logic [CW-1:0]             stored_q;
  logic signed [SampleW-1:0] min_q, max_q;
  logic                      ovf_q;
  logic [JW-1:0]             j_q;
  logic [BW-1:0]             b_q;
  logic [BinNumW-1:0]        e_q;
  logic [FracW-1:0]          span_q;
  logic [ProdW-1:0]          prod_q;
  logic signed [SampleW-1:0] edge_top_q;
  logic [CW-1:0]             prev_q;

  logic [FracW-1:0]          frac_tab [BIN_COUNT + 1];
  logic [FracW-1:0]          frac_sel;
  logic signed [SampleW:0]   new_edge;

  logic                      in_acc, store_wr, rd_en, out_load, emit_last;
  cell_ctrl_t                ctrl;

  logic signed [SampleW-1:0] edge_w [BIN_COUNT];
  logic [CW-1:0]             cnt_w  [BIN_COUNT];
  logic signed [SampleW-1:0] smp_w  [BIN_COUNT];
  logic                      vld_w  [BIN_COUNT];

  logic [SumW-1:0]           sum3;
  logic [SumW+DivMW-1:0]     quot_full;
  logic [CW-1:0]             smoothed;

  for (genvar g = 0; g <= BIN_COUNT; g++) begin : g_frac
    localparam logic [FracW-1:0] FVal = frac_q16(BIN_COUNT, g);
    assign frac_tab[g] = FVal;
  end

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_acc     = valid_i && in_ready_o;
  assign store_wr   = in_acc && (stored_q != CW'(STORE_DEPTH));
  assign rd_en      = (state_q == ST_BIN) && (b_q < BW'(stored_q));
  assign out_load   = (state_q == ST_EMIT) && (!out_valid_o || out_ready_i);
  assign emit_last  = (e_q == BinNumW'(NOut - 1));

  assign frac_sel = (j_q <= JW'(BIN_COUNT)) ? frac_tab[j_q[FW-1:0]] : '0;
  assign new_edge = {min_q[SampleW-1], min_q} + $signed({1'b0, prod_q[16 +: SampleW]});

  always_comb begin
    ctrl.clear      = (state_q == ST_CLEAR);
    ctrl.edge_shift = ((state_q == ST_EDGE) && (j_q != '0)) || out_load;
    ctrl.cnt_shift  = out_load;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (in_acc && end_of_set_i) state_d = ST_EDGE;
      ST_EDGE:  if (j_q == JW'(BIN_COUNT + 1)) state_d = ST_BIN;
      ST_BIN:   if (b_q == BW'(stored_q) + BW'(BIN_COUNT)) state_d = ST_EMIT;
      ST_EMIT:  if (out_load && emit_last) state_d = ST_CLEAR;
      ST_CLEAR: state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      stored_q    <= '0;
      min_q       <= 16'sh7fff;
      max_q       <= 16'sh8000;
      ovf_q       <= 1'b0;
      j_q         <= '0;
      b_q         <= '0;
      e_q         <= '0;
      rvld_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      rvld_q  <= rd_en;
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (out_load) out_valid_o <= 1'b1;
      unique case (state_q)
        ST_LOAD: begin
          j_q <= '0;
          if (store_wr) begin
            stored_q <= stored_q + CW'(1);
            if (sample_i < min_q) min_q <= sample_i;
            if (sample_i > max_q) max_q <= sample_i;
          end else if (in_acc) begin
            ovf_q <= 1'b1;
          end
        end
        ST_EDGE: begin
          j_q <= j_q + JW'(1);
          b_q <= '0;
        end
        ST_BIN: begin
          b_q <= b_q + BW'(1);
          e_q <= '0;
        end
        ST_EMIT: if (out_load) e_q <= e_q + BinNumW'(1);
        ST_CLEAR: begin
          stored_q <= '0;
          min_q    <= 16'sh7fff;
          max_q    <= 16'sh8000;
          ovf_q    <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // store: one write while loading, one registered read while binning
  always_ff @(posedge clk_i) begin
    if (store_wr) store_mem[stored_q[AW-1:0]] <= sample_i;
    if (rd_en) rdata_q <= store_mem[b_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    span_q <= FracW'(max_q - min_q);
    prod_q <= span_q * frac_sel;
    if ((state_q == ST_EDGE) && (j_q != '0)) edge_top_q <= new_edge[SampleW-1:0];
    if (out_load) prev_q <= smoothed;
  end

  for (genvar g = 0; g < BIN_COUNT; g++) begin : g_cell
    logic signed [SampleW-1:0] edge_nx;
    logic [CW-1:0]             cnt_nx;
    logic signed [SampleW-1:0] smp_in;
    logic                      vld_in;
    if (g == BIN_COUNT - 1) begin : g_top
      assign edge_nx = edge_top_q;
      assign cnt_nx  = '0;
    end else begin : g_mid
      assign edge_nx = edge_w[g+1];
      assign cnt_nx  = cnt_w[g+1];
    end
    if (g == 0) begin : g_bot
      assign smp_in = rdata_q;
      assign vld_in = rvld_q;
    end else begin : g_up
      assign smp_in = smp_w[g-1];
      assign vld_in = vld_w[g-1];
    end
    ebh_cell #(
      .CntW  (CW),
      .IsTop (g == BIN_COUNT - 1)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .edge_next_i (edge_nx),
      .cnt_next_i  (cnt_nx),
      .smp_i       (smp_in),
      .smp_vld_i   (vld_in),
      .edge_o      (edge_w[g]),
      .cnt_o       (cnt_w[g]),
      .smp_o       (smp_w[g]),
      .smp_vld_o   (vld_w[g])
    );
  end

  // divide by three through the reciprocal
  assign sum3      = SumW'(prev_q) + SumW'(cnt_w[0]) + SumW'(cnt_w[1]);
  assign quot_full = (SumW + DivMW)'(sum3) * (SumW + DivMW)'(DivMW'(DivM));

  always_comb begin
    if ((e_q == '0) || (32'(e_q) == BIN_COUNT - 1)) smoothed = cnt_w[0];
    else smoothed = CW'(quot_full >> DivSh);
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      bin_number_o     <= e_q;
      smoothed_count_o <= OutCntW'(smoothed);
      lower_edge_o     <= edge_w[0];
      dropped_o        <= ovf_q;
      final_bin_o      <= emit_last;
    end
  end

endmodule

// ===== dv/exponential_bin_histogram_tb.sv =====
// Self-checking testbench of the exponential-bin amplitude histogram.
`timescale 1ns / 100ps

module exponential_bin_histogram_tb;
  import ebh_pkg::*;

  localparam int NumBins    = 32;
  localparam int StoreDepth = 4096;
  localparam int NumDir     = 16;

  typedef struct {
    logic signed [15:0] lo_edge;
    logic        [12:0] cnt;
    logic        [4:0]  num;
    logic               drop;
    logic               fin;
  } bin_res_t;

  typedef struct {
    logic signed [15:0] smp;
    logic               eos;
    bit                 typed; // single-sample run, result known by inspection
  } dir_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      valid_i = 1'b0;
  logic                      in_ready_o;
  logic signed [SampleW-1:0] sample_i = '0;
  logic                      end_of_set_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [BinNumW-1:0]        bin_number_o;
  logic [OutCntW-1:0]        smoothed_count_o;
  logic signed [SampleW-1:0] lower_edge_o;
  logic                      dropped_o;
  logic                      final_bin_o;

  exponential_bin_histogram #(
    .BIN_COUNT  (NumBins),
    .STORE_DEPTH(StoreDepth)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .valid_i,
    .in_ready_o,
    .sample_i,
    .end_of_set_i,
    .out_valid_o,
    .out_ready_i,
    .bin_number_o,
    .smoothed_count_o,
    .lower_edge_o,
    .dropped_o,
    .final_bin_o
  );

  // Histogram shadow state
  longint   frac_tbl [NumBins+1];
  int       run_smp [$];
  int       run_min;
  int       run_max;
  bit       run_ovf;
  bin_res_t bins_due [$];
  int       n_err;
  int       src_pct;
  int       snk_pct;
  int       hold_gen;
  int       items_sent;
  dir_row_t dir_tbl [NumDir];

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Q0.16 fractions 2^(i/N)-1 from truncated Q2.30 powers
  function automatic void build_fracs();
    longint lo, hi, mid, acc;
    bit     ok;
    lo = 64'd1 << 30;
    hi = 64'd1 << 31;
    while (hi - lo > 1) begin
      mid = lo + ((hi - lo) >> 1);
      acc = 64'd1 << 30;
      ok  = 1'b1;
      for (int k = 0; k < NumBins; k++) begin
        if (ok) begin
          acc = (acc * mid) >> 30;
          if (acc > (64'd1 << 31)) ok = 1'b0;
        end
      end
      if (ok) lo = mid;
      else hi = mid;
    end
    acc = 64'd1 << 30;
    frac_tbl[0] = 0;
    for (int i = 1; i <= NumBins; i++) begin
      acc = (acc * lo) >> 30;
      frac_tbl[i] = (acc >= (64'd1 << 31)) ? 65536 : ((acc - (64'd1 << 30)) >> 14);
    end
    frac_tbl[NumBins] = 65536;
  endfunction

  function automatic void clear_run();
    run_smp.delete();
    run_min = 32767;
    run_max = -32768;
    run_ovf = 1'b0;
  endfunction

  // Fold one accepted request into the run; on end of set, fill res with the bins
  function automatic bit histogram_step(int s, bit eos, output bin_res_t res [NumBins]);
    longint span;
    int     edges [NumBins+1];
    int     cnts [NumBins];
    int     b;
    if (run_smp.size() < StoreDepth) begin
      run_smp = {run_smp, s};
      if (s < run_min) run_min = s;
      if (s > run_max) run_max = s;
    end else begin
      run_ovf = 1'b1;
    end
    if (!eos) return 1'b0;
    span = run_max - run_min;
    for (int i = 0; i <= NumBins; i++) edges[i] = run_min + int'((span * frac_tbl[i]) >> 16);
    foreach (cnts[i]) cnts[i] = 0;
    foreach (run_smp[k]) begin
      b = 0;
      for (int i = 0; i <= NumBins; i++) if (edges[i] <= run_smp[k]) b = i;
      if (b > NumBins - 1) b = NumBins - 1;
      cnts[b]++;
    end
    for (int i = 1; i < NumBins - 1; i++) cnts[i] = (cnts[i-1] + cnts[i] + cnts[i+1]) / 3;
    for (int i = 0; i < NumBins; i++) begin
      res[i].num     = 5'(i);
      res[i].cnt     = 13'(cnts[i]);
      res[i].lo_edge = 16'(edges[i]);
      res[i].drop    = run_ovf;
      res[i].fin     = (i == NumBins - 1);
    end
    clear_run();
    return 1'b1;
  endfunction

  task automatic send_sample(logic signed [15:0] s, logic eos, bit typed);
    bin_res_t res [NumBins];
    while ($urandom_range(99) < src_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i      <= 1'b1;
    sample_i     <= s;
    end_of_set_i <= eos;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (histogram_step(int'(s), eos, res)) begin
      for (int i = 0; i < NumBins; i++) begin
        // lone sample: every edge equals it, it lands in the top bin
        if (typed) begin
          res[i].cnt     = (i == NumBins - 1) ? 13'd1 : 13'd0;
          res[i].lo_edge = s;
          res[i].drop    = 1'b0;
        end
        bins_due = {bins_due, res[i]};
      end
    end
  endtask

  function automatic logic signed [15:0] pick_sample(int base, bit narrow);
    case ($urandom_range(7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      default: return narrow ? 16'(base + $urandom_range(15)) : 16'($urandom);
    endcase
  endfunction

  task automatic send_run(int len);
    int base;
    bit narrow;
    base   = $urandom_range(65535) - 32768;
    narrow = ($urandom_range(3) == 0);
    for (int k = 0; k < len; k++) send_sample(pick_sample(base, narrow), k == len - 1, 1'b0);
  endtask

  // Receiver: random back-pressure plus long hold-offs on request
  initial begin
    int seen_gen;
    int hold_left;
    seen_gen  = 0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_gen != seen_gen) begin
        seen_gen  = hold_gen;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= snk_pct);
      end
    end
  end

  // Compare each accepted result with the oldest pending bin
  initial begin
    bin_res_t e;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (bins_due.size() == 0) begin
          $error("unexpected result, bin %0d", bin_number_o);
          n_err++;
        end else begin
          e = bins_due.pop_front();
          if (bin_number_o !== e.num) begin
            $error("bin_number exp %0d got %0d", e.num, bin_number_o);
            n_err++;
          end
          if (smoothed_count_o !== e.cnt) begin
            $error("smoothed_count exp %0d got %0d", e.cnt, smoothed_count_o);
            n_err++;
          end
          if (lower_edge_o !== e.lo_edge) begin
            $error("lower_edge exp %0d got %0d", e.lo_edge, lower_edge_o);
            n_err++;
          end
          if (dropped_o !== e.drop) begin
            $error("dropped exp %0d got %0d", e.drop, dropped_o);
            n_err++;
          end
          if (final_bin_o !== e.fin) begin
            $error("final_bin exp %0d got %0d", e.fin, final_bin_o);
            n_err++;
          end
        end
      end
    end
  end

  initial begin
    int waited;
    n_err      = 0;
    hold_gen   = 0;
    items_sent = 0;
    src_pct    = 10;
    snk_pct    = 53;
    build_fracs();
    clear_run();
    dir_tbl = '{
      '{-16'sd32768, 1'b1, 1'b1},
      '{16'sd32767,  1'b1, 1'b1},
      '{16'sd0,      1'b1, 1'b1},
      '{16'sd5,      1'b0, 1'b0},  // equal extremes
      '{16'sd5,      1'b0, 1'b0},
      '{16'sd5,      1'b1, 1'b0},
      '{-16'sd32768, 1'b0, 1'b0},  // full span
      '{16'sd32767,  1'b0, 1'b0},
      '{16'sd0,      1'b0, 1'b0},
      '{16'sd100,    1'b0, 1'b0},
      '{-16'sd100,   1'b0, 1'b0},
      '{-16'sd1,     1'b1, 1'b0},
      '{16'sd1000,   1'b0, 1'b0},
      '{16'sd1001,   1'b0, 1'b0},
      '{16'sd1003,   1'b0, 1'b0},
      '{16'sd1010,   1'b1, 1'b0}
    };
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[r]) send_sample(dir_tbl[r].smp, dir_tbl[r].eos, dir_tbl[r].typed);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin src_pct = 10; snk_pct = 53; end
        1: begin src_pct = 53; snk_pct = 10; end
        default: begin src_pct = 0; snk_pct = 0; hold_gen++; end
      endcase
      while (items_sent < (ph + 1) * 110)
        send_run(($urandom_range(7) == 0) ? $urandom_range(21, 60) : $urandom_range(1, 20));
    end
    valid_i <= 1'b0;

    waited = 0;
    while (bins_due.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (50) @(posedge clk_i);
    if (n_err == 0 && bins_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
